>>> sv/psd_pkg.sv
package psd_pkg;

	typedef struct packed {
		logic signed [15:0] rx_i;
		logic signed [15:0] rx_q;
	} psd_in_t;

	typedef struct packed {
		logic signed [19:0] llr;
		logic [2:0]         bit_pos;
		logic               last;
	} psd_out_t;

	// Metric width: distance up to 2^34, times 2^16, over 2^26 gives 2^24.
	localparam int MetricW = 26;
	localparam int LlrW    = 20;

	// Quarter-wave cosine table, Q1.13, cos(k*pi/64) for k = 0..32.
	function automatic logic [13:0] cos_quarter(input logic [5:0] k);
		logic [13:0] v;
		begin
			case (k)
				6'd0: v = 14'd8192;  6'd1: v = 14'd8182;  6'd2: v = 14'd8153;
				6'd3: v = 14'd8103;  6'd4: v = 14'd8035;  6'd5: v = 14'd7946;
				6'd6: v = 14'd7839;  6'd7: v = 14'd7713;  6'd8: v = 14'd7568;
				6'd9: v = 14'd7405;  6'd10: v = 14'd7225; 6'd11: v = 14'd7027;
				6'd12: v = 14'd6811; 6'd13: v = 14'd6580; 6'd14: v = 14'd6332;
				6'd15: v = 14'd6070; 6'd16: v = 14'd5793; 6'd17: v = 14'd5501;
				6'd18: v = 14'd5197; 6'd19: v = 14'd4880; 6'd20: v = 14'd4551;
				6'd21: v = 14'd4212; 6'd22: v = 14'd3862; 6'd23: v = 14'd3503;
				6'd24: v = 14'd3135; 6'd25: v = 14'd2760; 6'd26: v = 14'd2378;
				6'd27: v = 14'd1990; 6'd28: v = 14'd1598; 6'd29: v = 14'd1202;
				6'd30: v = 14'd803;  6'd31: v = 14'd402;  default: v = 14'd0;
			endcase
			return v;
		end
	endfunction

	// Full-circle cosine, k modulo 128.
	function automatic logic signed [15:0] cos64(input logic [6:0] k);
		logic [13:0] m;
		logic        neg;
		begin
			if (k <= 7'd32) begin
				m = cos_quarter(k[5:0]); neg = 1'b0;
			end else if (k <= 7'd64) begin
				m = cos_quarter(6'(7'd64 - k)); neg = 1'b1;
			end else if (k <= 7'd96) begin
				m = cos_quarter(6'(k - 7'd64)); neg = 1'b1;
			end else begin
				m = cos_quarter(6'(8'd128 - {1'b0, k})); neg = 1'b0;
			end
			return neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
		end
	endfunction

	// Max-star correction, round(256*ln(1+exp(-i/2))).
	function automatic logic [7:0] corr_lut(input logic [2:0] i);
		logic [7:0] v;
		begin
			case (i)
				3'd0: v = 8'd177; 3'd1: v = 8'd121; 3'd2: v = 8'd80;
				3'd3: v = 8'd52;  3'd4: v = 8'd32;  3'd5: v = 8'd20;
				3'd6: v = 8'd12;  default: v = 8'd8;
			endcase
			return v;
		end
	endfunction

endpackage

>>> sv/psd_front.sv
module psd_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  psd_pkg::psd_in_t       in_data,
	input  logic [15:0]            inv_noise_var,
	output logic                   q_valid,
	input  logic                   q_stall,
	output psd_pkg::psd_in_t       q_data,
	output logic [15:0]            q_inv
);
	import psd_pkg::*;

	localparam int Depth = 2;

	psd_in_t     mem_q [Depth];
	logic [15:0] inv_q [Depth];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	logic        push, pop;

	// Two-entry request queue; the noise scale is captured with each sample.
	assign in_stall = (cnt_q == 2'(Depth));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_valid && !q_stall;
	assign q_data   = mem_q[rp_q];
	assign q_inv    = inv_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_data;
			inv_q[wp_q] <= inv_noise_var;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

>>> sv/psd_back.sv
module psd_back #(
	parameter int SYM_BITS = 3
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	output logic                   q_stall,
	input  psd_pkg::psd_in_t       q_data,
	input  logic [15:0]            q_inv,
	output logic                   out_valid,
	input  logic                   out_stall,
	output psd_pkg::psd_out_t      out_data
);
	import psd_pkg::*;

	localparam int Npts = 1 << SYM_BITS;
	localparam int PtW  = (SYM_BITS > 1) ? SYM_BITS : 1;
	localparam int BW   = 3;

	// Constellation point for index j, built from the recursive bit mapping.
	function automatic logic [31:0] point(input int j);
		int s;
		logic [6:0] k;
		begin
			s = 1 - 2 * (j & 1);
			for (int l = 1; l < SYM_BITS; l++)
				s = (1 - 2 * ((j >> l) & 1)) * ((1 << l) - s);
			k = 7'((s + 1) * (1 << (6 - SYM_BITS)));
			return {cos64(k), cos64(7'(k - 7'd32))};
		end
	endfunction

	logic signed [MetricW-1:0] metric_q [Npts];
	logic signed [MetricW-1:0] l0_q, l1_q;
	logic                      v0_q, v1_q;
	logic [PtW-1:0]            j_q;
	logic [PtW-1:0]            j_sh;
	logic [BW-1:0]             b_q;
	logic                      busy_q, mphase_q;
	psd_in_t                   y_q;
	logic [15:0]               inv_q;
	logic signed [16:0]        di, dq;
	logic [33:0]               dist_s1;
	logic [PtW-1:0]            jm_s1;
	logic                      vm_s1;
	logic [49:0]               prod;
	logic signed [MetricW-1:0] m_cur, acc, acc_new;
	logic                      v_cur, sel1;
	logic signed [MetricW:0]   diff, mx;
	logic [MetricW:0]          ad;
	logic signed [MetricW:0]   llr_w;
	logic                      out_valid_q;
	psd_out_t                  out_q;
	logic                      j_last, emit;
	logic [31:0]               pt;

	assign q_stall   = busy_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign j_last    = (j_q == PtW'(Npts - 1));
	assign pt        = point(int'(j_q));

	// Metric phase: squared distance, registered, then scaled and rounded.
	assign di   = 17'(y_q.rx_i) - 17'($signed(pt[31:16]));
	assign dq   = 17'(y_q.rx_q) - 17'($signed(pt[15:0]));
	assign prod = 50'(dist_s1) * 50'(inv_q);

	// Combine phase: max-star of accumulator with point j of the set.
	assign j_sh    = j_q >> b_q;
	assign sel1    = j_sh[0];
	assign m_cur   = metric_q[j_q];
	assign v_cur   = sel1 ? v1_q : v0_q;
	assign acc     = sel1 ? l1_q : l0_q;
	assign diff    = (MetricW+1)'(acc) - (MetricW+1)'(m_cur);
	assign mx      = diff[MetricW] ? (MetricW+1)'(m_cur) : (MetricW+1)'(acc);
	assign ad      = diff[MetricW] ? (MetricW+1)'(-diff) : diff;
	always_comb begin
		if (!v_cur) acc_new = m_cur;
		else if (ad < (MetricW+1)'(1024))
			acc_new = MetricW'(mx + (MetricW+1)'(corr_lut(ad[9:7])));
		else acc_new = MetricW'(mx);
	end
	assign llr_w = (MetricW+1)'(sel1 ? l0_q : acc_new) - (MetricW+1)'(sel1 ? acc_new : l1_q);
	assign emit  = busy_q && !mphase_q && j_last && (!out_valid_q || !out_stall);

	always_ff @(posedge clk) begin
		if (q_valid && !busy_q) begin
			y_q <= q_data; inv_q <= q_inv;
			v0_q <= 1'b0; v1_q <= 1'b0;
		end
		dist_s1 <= $unsigned(34'(di) * 34'(di) + 34'(dq) * 34'(dq));
		jm_s1   <= j_q;
		if (vm_s1)
			metric_q[jm_s1] <= -MetricW'((prod + 50'(1 << 25)) >> 26);
		// The last metric is still being written while vm_s1 is high.
		if (busy_q && !mphase_q && !vm_s1 && (!j_last || emit)) begin
			if (j_last) begin
				v0_q <= 1'b0; v1_q <= 1'b0;
			end else if (sel1) begin
				l1_q <= acc_new; v1_q <= 1'b1;
			end else begin
				l0_q <= acc_new; v0_q <= 1'b1;
			end
		end
		if (emit) begin
			out_q.bit_pos <= b_q;
			out_q.last    <= (b_q == BW'(SYM_BITS - 1));
			if (llr_w > (MetricW+1)'(524287)) out_q.llr <= 20'sd524287;
			else if (llr_w < -(MetricW+1)'(524288)) out_q.llr <= -20'sd524288;
			else out_q.llr <= LlrW'(llr_w);
		end
	end

	// Sequencer: metric sweep over all points, then one sweep per bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; mphase_q <= 1'b0; j_q <= '0; b_q <= '0;
			vm_s1 <= 1'b0; out_valid_q <= 1'b0;
		end else begin
			vm_s1 <= busy_q && mphase_q;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (emit) out_valid_q <= 1'b1;
			if (!busy_q) begin
				if (q_valid) begin
					busy_q <= 1'b1; mphase_q <= 1'b1; j_q <= '0; b_q <= '0;
				end
			end else if (mphase_q) begin
				if (j_last) begin
					mphase_q <= 1'b0; j_q <= '0;
				end else j_q <= j_q + 1'b1;
			end else if (!vm_s1) begin
				if (!j_last) j_q <= j_q + 1'b1;
				else if (emit) begin
					j_q <= '0;
					if (b_q == BW'(SYM_BITS - 1)) busy_q <= 1'b0;
					else b_q <= b_q + 1'b1;
				end
			end
		end
	end
endmodule

>>> sv/psk_soft_demapper_core.sv
// Each sample first fills the metric table, then takes one sweep over all points per bit LLR.
// Samples are handled one at a time by the single distance and max-star unit, which
// visits every constellation point in turn; the two-entry input queue buffers further samples.
// Reset clears the queue, sequencer and output valid; inv_noise_var resets to 256.
module psk_soft_demapper_core #(
	parameter int SYM_BITS = 3
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [15:0]            cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  psd_pkg::psd_in_t       in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output psd_pkg::psd_out_t      out_data
);
	import psd_pkg::*;

	logic [15:0] inv_q, q_inv;
	logic        q_valid, q_stall;
	psd_in_t     q_data;

	// Noise scale register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) inv_q <= 16'd256;
		else if (cfg_we) inv_q <= cfg_wdata;
	end

	psd_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.inv_noise_var(inv_q), .q_valid, .q_stall, .q_data, .q_inv
	);

	psd_back #(.SYM_BITS(SYM_BITS)) u_back (
		.clk, .arst_n, .q_valid, .q_stall, .q_data, .q_inv,
		.out_valid, .out_stall, .out_data
	);
endmodule

>>> tb/testbench.sv
module testbench;
	import psd_pkg::*;

	localparam int Bps = 3;
	localparam int Npts = 1 << Bps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	psd_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	psd_out_t out_data;

	psk_soft_demapper_core #(.SYM_BITS(Bps)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Model copy of the block's state.
	logic signed [15:0] pt_cos [Npts];
	logic signed [15:0] pt_sin [Npts];
	logic [15:0] noise_scale;

	psd_out_t llr_queue [$];
	int mismatches = 0;
	int requests_sent = 0;
	int llrs_seen = 0;
	int out_hold = 0;
	bit rx_idle_ok = 1'b1;

	const int cos_tab [33] = '{
		8192, 8182, 8153, 8103, 8035, 7946, 7839, 7713,
		7568, 7405, 7225, 7027, 6811, 6580, 6332, 6070,
		5793, 5501, 5197, 4880, 4551, 4212, 3862, 3503,
		3135, 2760, 2378, 1990, 1598, 1202, 803, 402, 0};
	const longint corr_tab [8] = '{177, 121, 80, 52, 32, 20, 12, 8};

	function automatic int circle_cos(int k);
		int q;
		q = k & 127;
		if (q <= 32) return cos_tab[q];
		if (q <= 64) return -cos_tab[64 - q];
		if (q <= 96) return -cos_tab[q - 64];
		return cos_tab[128 - q];
	endfunction

	// Build the constellation with the recursive bit-to-phase rule.
	task automatic build_points();
		int s;
		int k;
		for (int j = 0; j < Npts; j++) begin
			s = 1 - 2 * (j & 1);
			for (int l = 1; l < Bps; l++)
				s = (1 - 2 * ((j >> l) & 1)) * ((1 << l) - s);
			k = (s + 1) * (1 << (6 - Bps));
			pt_cos[j] = 16'(circle_cos(k));
			pt_sin[j] = 16'(circle_cos(k - 32));
		end
	endtask

	function automatic longint jac_log_add(longint a, longint b);
		longint m;
		longint d;
		m = (a > b) ? a : b;
		d = (a > b) ? a - b : b - a;
		if (d < 1024) m += corr_tab[d >> 7];
		return m;
	endfunction

	// Predict the bit LLRs of one sample and queue them.
	task automatic predict_llrs(psd_in_t s);
		longint metric [Npts];
		longint di;
		longint dq;
		longint l0;
		longint l1;
		longint llr;
		bit v0;
		bit v1;
		longint unsigned p;
		psd_out_t r;
		for (int j = 0; j < Npts; j++) begin
			di = longint'(s.rx_i) - longint'(pt_cos[j]);
			dq = longint'(s.rx_q) - longint'(pt_sin[j]);
			p = longint'(di * di + dq * dq) * longint'(noise_scale);
			metric[j] = -longint'((p + (64'd1 << 25)) >> 26);
		end
		for (int b = 0; b < Bps; b++) begin
			v0 = 0; v1 = 0; l0 = 0; l1 = 0;
			for (int j = 0; j < Npts; j++) begin
				if (((j >> b) & 1) == 0) begin
					l0 = v0 ? jac_log_add(l0, metric[j]) : metric[j];
					v0 = 1;
				end else begin
					l1 = v1 ? jac_log_add(l1, metric[j]) : metric[j];
					v1 = 1;
				end
			end
			llr = l0 - l1;
			if (llr > 524287) llr = 524287;
			if (llr < -524288) llr = -524288;
			r.llr = 20'(llr);
			r.bit_pos = 3'(b);
			r.last = (b == Bps - 1);
			llr_queue.push_back(r);
		end
	endtask

	// Send one sample request after a random gap; valid stays high only
	// when the next request follows with no gap.
	task automatic send_sample(logic [15:0] i_val, logic [15:0] q_val);
		psd_in_t s;
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s.rx_i = i_val;
		s.rx_q = q_val;
		in_data <= s;
		in_valid <= 1'b1;
		predict_llrs(s);
		do @(posedge clk); while (in_stall);
		requests_sent++;
	endtask

	// Wait until all LLRs are back and the block has drained, then write the register.
	task automatic set_noise_scale(logic [15:0] v);
		in_valid <= 1'b0;
		while (llr_queue.size() != 0) @(posedge clk);
		repeat ((Bps + 1) * Npts + 8) @(posedge clk);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		noise_scale = v;
	endtask

	// After each accepted LLR the result side stalls for a random number of
	// cycles, except in the stall-free stretches.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_hold = 0;
			out_stall <= 1'b0;
		end else if (out_valid && !out_stall) begin
			out_hold = rx_idle_ok ? $urandom_range(0, 12) : 0;
			out_stall <= (out_hold != 0);
		end else if (out_hold != 0) begin
			out_hold--;
			out_stall <= (out_hold != 0);
		end
	end

	// Compare each accepted LLR with the oldest prediction.
	always @(posedge clk) begin
		psd_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			llrs_seen++;
			if (llr_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected llr %p", out_data);
			end else begin
				want = llr_queue.pop_front();
				if (out_data.llr !== want.llr || out_data.bit_pos !== want.bit_pos ||
						out_data.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, out_data);
				end
			end
		end
	end

	task automatic test_extremes();
		send_sample(16'h7fff, 16'h7fff);
		send_sample(16'h8000, 16'h8000);
		send_sample(16'h7fff, 16'h8000);
		send_sample(16'h8000, 16'h7fff);
		send_sample(16'h0000, 16'h0000);
		send_sample(16'hffff, 16'h0001);
		send_sample(16'(pt_cos[3]), 16'(pt_sin[3]));
		send_sample(16'h5555, 16'haaaa);
	endtask

	// Saturation of the final LLR with the largest scale, then samples with a zero scale.
	task automatic test_saturation();
		set_noise_scale(16'hffff);
		send_sample(16'h7fff, 16'h0000);
		send_sample(16'h8000, 16'h8000);
		send_sample(16'h1000, 16'hf000);
		set_noise_scale(16'h0000);
		send_sample(16'h7fff, 16'h7fff);
		send_sample(16'h1234, 16'h8765);
	endtask

	// Small scales put metric gaps inside the max-star correction range.
	task automatic test_random(int count);
		logic [15:0] scales [6] = '{16'd1, 16'd16, 16'd256, 16'd1000, 16'h8000, 16'hffff};
		int j;
		for (int n = 0; n < count; n++) begin
			if (n % 60 == 0) begin
				rx_idle_ok = (n % 120 == 0);
				set_noise_scale(n % 120 == 60 ? 16'($urandom) : scales[(n / 60) % 6]);
			end
			if ($urandom_range(0, 3) == 0) begin
				send_sample(16'($urandom), 16'($urandom));
			end else begin
				j = $urandom_range(0, Npts - 1);
				send_sample(16'(pt_cos[j] + $signed(11'($urandom))),
					16'(pt_sin[j] + $signed(11'($urandom))));
			end
		end
	endtask

	initial begin
		build_points();
		noise_scale = 16'd256;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_saturation();
		test_random(346);
		in_valid <= 1'b0;
		while (llr_queue.size() != 0) @(posedge clk);
		repeat ((Bps + 1) * Npts + 20) @(posedge clk);
		$display("Sent %0d samples over several noise scales, checked %0d LLRs.",
			requests_sent, llrs_seen);
		if (mismatches == 0 && llr_queue.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches, %0d LLRs missing", mismatches, llr_queue.size());
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("timeout");
		$display("simulation failed");
		$finish;
	end

endmodule

>>> psk_soft_demapper_core.f
sv/psd_pkg.sv
sv/psd_front.sv
sv/psd_back.sv
sv/psk_soft_demapper_core.sv
tb/testbench.sv
